// ----- design/utd_pkg.sv -----
// Shared types and constants of the Unicode text decoder.
// No dependencies; every other file of the decoder imports this package.
package utd_pkg;

    localparam int BYTE_W   = 8;
    localparam int CP_W     = 21;
    localparam int STATUS_W = 2;
    localparam int ENC_W    = 3;

    // Text encoding register codes.
    localparam logic [ENC_W-1:0] ENC_UTF8     = 3'd0;
    localparam logic [ENC_W-1:0] ENC_UTF8_BOM = 3'd1;
    localparam logic [ENC_W-1:0] ENC_UTF16LE  = 3'd2;
    localparam logic [ENC_W-1:0] ENC_UTF16BE  = 3'd3;
    localparam logic [ENC_W-1:0] ENC_ANSI     = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_CODE_POINT = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ERROR      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_END        = 2'd2;

    localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;
    localparam logic [CP_W-1:0] BOM_CP    = 21'h00FEFF;
    localparam logic [CP_W-1:0] SURR_MIN  = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_MAX  = 21'h00DFFF;

    localparam logic [15:0] HI_SURR_FIRST = 16'hD800;
    localparam logic [15:0] HI_SURR_LAST  = 16'hDBFF;
    localparam logic [15:0] LO_SURR_FIRST = 16'hDC00;
    localparam logic [15:0] LO_SURR_LAST  = 16'hDFFF;

    // Queue between the classifier and the decoder.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One classified byte as it waits in the queue.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              is_ascii;
        logic              is_lead2;
        logic              is_lead3;
        logic              is_lead4;
        logic              is_cont;
    } t_q_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

// ----- design/utd_byte_if.sv -----
// Request channel that carries raw text bytes into the decoder.
// Depends on utd_pkg for the byte width.
interface utd_byte_if;
    import utd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- design/utd_cp_if.sv -----
// Request channel that carries decoded code points out of the decoder.
// Depends on utd_pkg for the field widths.
interface utd_cp_if;
    import utd_pkg::*;

    logic                valid;
    logic                ready;
    logic [CP_W-1:0]     code_point;
    logic [STATUS_W-1:0] status;
    logic                end_mark;

    modport source (output valid, output code_point, output status, output end_mark,
                    input ready);
    modport sink   (input valid, input code_point, input status, input end_mark,
                    output ready);
endinterface

// ----- design/utd_front.sv -----
// Front end: accepts byte requests and classifies each byte for the decoder.
// Depends on utd_pkg and utd_byte_if.
module utd_front (
    utd_byte_if.sink          i_in,
    input  utd_pkg::t_q_status i_q_status,
    output utd_pkg::t_q_entry  o_entry,
    output logic               o_push
);
    import utd_pkg::*;

    assign i_in.ready = !i_q_status.full;
    assign o_push     = i_in.valid && !i_q_status.full;

    always_comb begin
        o_entry.data     = i_in.data_byte;
        o_entry.last     = i_in.last_byte;
        o_entry.is_ascii = !i_in.data_byte[7];
        o_entry.is_lead2 = i_in.data_byte[7:5] == 3'b110;
        o_entry.is_lead3 = i_in.data_byte[7:4] == 4'b1110;
        o_entry.is_lead4 = i_in.data_byte[7:3] == 5'b11110;
        o_entry.is_cont  = i_in.data_byte[7:6] == 2'b10;
    end
endmodule

// ----- design/utd_queue.sv -----
// Short register queue that decouples the classifier from the decoder.
// Depends on utd_pkg for the entry type and depth.
module utd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  utd_pkg::t_q_entry  i_entry,
    input  logic               i_pop,
    output utd_pkg::t_q_entry  o_entry,
    output utd_pkg::t_q_status o_status
);
    import utd_pkg::*;

    t_q_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic [Q_PTR_W-1:0]   n_wr_ptr;
    logic [Q_PTR_W-1:0]   n_rd_ptr;

    assign n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_entry        = r_mem[r_rd_ptr];
    assign o_status.empty = r_count == '0;
    assign o_status.full  = r_count == Q_CNT_W'(Q_DEPTH);
endmodule

// ----- design/utd_back.sv -----
// Back end: decodes queued bytes and holds each result in the output register.
// Depends on utd_pkg and utd_cp_if.
module utd_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_restart,
    input  logic [utd_pkg::ENC_W-1:0] i_text_encoding,
    input  utd_pkg::t_q_status       i_q_status,
    input  utd_pkg::t_q_entry        i_entry,
    output logic                     o_pop,
    utd_cp_if.source                 o_out
);
    import utd_pkg::*;

    localparam logic [1:0] K_NONE = 2'd0;
    localparam logic [1:0] K_CP   = 2'd1;
    localparam logic [1:0] K_ERR  = 2'd2;

    logic [CP_W-1:0]     r_acc;
    logic [2:0]          r_br;
    logic [2:0]          r_sl;
    logic                r_hs;
    logic                r_start;
    logic                r_err;
    logic [CP_W-1:0]     n_acc;
    logic [2:0]          n_br;
    logic [2:0]          n_sl;
    logic                n_hs;
    logic                n_start;
    logic                n_err;

    logic                r_valid;
    logic [CP_W-1:0]     r_cp;
    logic [STATUS_W-1:0] r_status;
    logic                r_end;

    logic [1:0]          kind;
    logic [CP_W-1:0]     cp;
    logic [CP_W-1:0]     acc_shift;
    logic [CP_W-1:0]     least;
    logic [7:0]          first;
    logic [15:0]         unit;
    logic                res_valid;
    logic [STATUS_W-1:0] res_status;
    logic                can_take;

    assign can_take = !r_valid || o_out.ready;
    assign o_pop    = !i_q_status.empty && can_take;

    always_comb begin
        n_acc      = r_acc;
        n_br       = r_br;
        n_sl       = r_sl;
        n_hs       = r_hs;
        n_start    = r_start;
        n_err      = r_err;
        kind       = K_NONE;
        cp         = '0;
        res_valid  = 1'b0;
        res_status = ST_END;
        acc_shift  = {r_acc[14:0], i_entry.data[5:0]};
        first      = r_acc[17:10];
        unit       = (i_text_encoding == ENC_UTF16LE) ? {i_entry.data, first}
                                                      : {first, i_entry.data};
        unique case (r_sl)
            3'd2:    least = 21'h000080;
            3'd3:    least = 21'h000800;
            default: least = SUPP_BASE;
        endcase

        if (!r_err) begin
            unique case (i_text_encoding)
                ENC_UTF8, ENC_UTF8_BOM: begin
                    if (r_br == 3'd0) begin
                        priority if (i_entry.is_ascii) begin
                            kind = K_CP;
                            cp   = {13'b0, i_entry.data};
                        end else if (i_entry.is_lead2) begin
                            n_acc = {16'b0, i_entry.data[4:0]};
                            n_sl  = 3'd2;
                            n_br  = 3'd1;
                        end else if (i_entry.is_lead3) begin
                            n_acc = {17'b0, i_entry.data[3:0]};
                            n_sl  = 3'd3;
                            n_br  = 3'd2;
                        end else if (i_entry.is_lead4) begin
                            n_acc = {18'b0, i_entry.data[2:0]};
                            n_sl  = 3'd4;
                            n_br  = 3'd3;
                        end else begin
                            kind = K_ERR;
                        end
                    end else if (!i_entry.is_cont) begin
                        kind = K_ERR;
                    end else if (r_br == 3'd1) begin
                        // Final byte of the sequence: range and form checks.
                        n_acc = '0;
                        n_sl  = '0;
                        n_br  = '0;
                        if (acc_shift < least || acc_shift > CP_MAX ||
                            (acc_shift >= SURR_MIN && acc_shift <= SURR_MAX)) begin
                            kind = K_ERR;
                        end else begin
                            kind = K_CP;
                            cp   = acc_shift;
                        end
                    end else begin
                        n_acc = acc_shift;
                        n_br  = r_br - 3'd1;
                    end
                end
                ENC_UTF16LE, ENC_UTF16BE: begin
                    if (r_br == 3'd0) begin
                        n_acc = {3'b0, i_entry.data, r_acc[9:0]};
                        n_br  = 3'd1;
                    end else begin
                        n_br  = '0;
                        n_acc = {11'b0, r_acc[9:0]};
                        if (r_hs) begin
                            n_hs  = 1'b0;
                            n_acc = '0;
                            if (unit < LO_SURR_FIRST || unit > LO_SURR_LAST) begin
                                kind = K_ERR;
                            end else begin
                                kind = K_CP;
                                cp   = SUPP_BASE + {1'b0, r_acc[9:0], unit[9:0]};
                            end
                        end else if (unit >= HI_SURR_FIRST && unit <= HI_SURR_LAST) begin
                            n_acc = {11'b0, unit[9:0]};
                            n_hs  = 1'b1;
                        end else if (unit >= LO_SURR_FIRST && unit <= LO_SURR_LAST) begin
                            kind = K_ERR;
                        end else begin
                            kind = K_CP;
                            cp   = {5'b0, unit};
                        end
                    end
                end
                ENC_ANSI: begin
                    if (i_entry.is_ascii) begin
                        kind = K_CP;
                        cp   = {13'b0, i_entry.data};
                    end else begin
                        kind = K_ERR;
                    end
                end
                default: begin
                    kind = K_ERR;
                end
            endcase

            // A byte-order mark as the first code point of the stream is dropped.
            if (kind == K_CP) begin
                if (r_start && cp == BOM_CP && i_text_encoding <= ENC_UTF16BE) begin
                    kind = K_NONE;
                end
                n_start = 1'b0;
            end
            if (kind == K_NONE && i_entry.last && (n_br != 3'd0 || n_hs)) begin
                kind = K_ERR;
            end

            if (kind == K_ERR) begin
                res_valid  = 1'b1;
                res_status = ST_ERROR;
                cp         = '0;
                n_err      = 1'b1;
            end else if (kind == K_CP) begin
                res_valid  = 1'b1;
                res_status = ST_CODE_POINT;
            end else if (i_entry.last) begin
                // A dropped mark may still sit in cp; an end result carries zero.
                res_valid  = 1'b1;
                res_status = ST_END;
                cp         = '0;
            end
        end else if (i_entry.last) begin
            res_valid  = 1'b1;
            res_status = ST_END;
        end

        // The last byte of a stream returns the decoder to its start state.
        if (i_entry.last) begin
            n_acc   = '0;
            n_br    = '0;
            n_sl    = '0;
            n_hs    = 1'b0;
            n_start = 1'b1;
            n_err   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_acc   <= '0;
            r_br    <= '0;
            r_sl    <= '0;
            r_hs    <= 1'b0;
            r_start <= 1'b1;
            r_err   <= 1'b0;
        end else if (o_pop) begin
            r_acc   <= n_acc;
            r_br    <= n_br;
            r_sl    <= n_sl;
            r_hs    <= n_hs;
            r_start <= n_start;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop && res_valid) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && res_valid) begin
            r_cp     <= cp;
            r_status <= res_status;
            r_end    <= i_entry.last;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.code_point = r_cp;
    assign o_out.status     = r_status;
    assign o_out.end_mark   = r_end;
endmodule

// ----- design/unicode_text_decoder.sv -----
// Unicode text decoder: bytes in, code points out; UTF-8, UTF-16LE/BE or ANSI.
// Path: each accepted byte is written into the queue register, decoded from there,
// and its result is held in the output register until it is taken.
// Throughput: one byte per cycle while the output register is free or being emptied.
// Reset is synchronous and active low: mode UTF-8, queue empty, no result.
// A mode write also restarts the stream; no clearing pass is needed.
module unicode_text_decoder (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [utd_pkg::ENC_W-1:0] i_cfg_wr_data,
    utd_byte_if.sink                  i_in,
    utd_cp_if.source                  o_out
);
    import utd_pkg::*;

    // The mode register feeds the decoder directly; the user writes it only while the
    // block is idle, not enforced here, so no request in flight sees a mode change.
    logic [ENC_W-1:0] r_text_encoding;

    t_q_entry  front_entry;
    t_q_entry  q_entry;
    t_q_status q_status;
    logic      q_push;
    logic      q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_encoding <= ENC_UTF8;
        end else if (i_cfg_wr_en) begin
            r_text_encoding <= i_cfg_wr_data;
        end
    end

    // The front end takes a byte request whenever the queue has room and
    // tags it with its UTF-8 byte class, so the decoder only has to combine
    // the class with its own state.
    utd_front u_front (
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_entry    (front_entry),
        .o_push     (q_push)
    );

    // The queue lets the input side keep taking bytes while a result waits
    // at the output, and lets the decoder drain while the source idles.
    utd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_entry  (front_entry),
        .i_pop    (q_pop),
        .o_entry  (q_entry),
        .o_status (q_status)
    );

    // The decoder consumes one byte per cycle whenever its output register
    // is free or being emptied, and produces at most one result per byte.
    utd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_restart       (i_cfg_wr_en),
        .i_text_encoding (r_text_encoding),
        .i_q_status      (q_status),
        .i_entry         (q_entry),
        .o_pop           (q_pop),
        .o_out           (o_out)
    );

    // A code point result is always a Unicode scalar value.
    a_cp_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == ST_CODE_POINT |->
            o_out.code_point <= CP_MAX &&
            !(o_out.code_point >= SURR_MIN && o_out.code_point <= SURR_MAX))
        else $error("code point result outside the scalar value range");

    // Error and end results carry a zero code point.
    a_non_cp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status != ST_CODE_POINT |-> o_out.code_point == '0)
        else $error("non code point result carries a code point");

    // The decoder never leaves a queued byte waiting while it can deliver.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_status.empty && (!o_out.valid || o_out.ready) |-> q_pop)
        else $error("decoder stalled with a free output register");

    // A full queue means the output side was stalled at the previous edge.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> $past(o_out.valid && !o_out.ready))
        else $error("queue filled while the output was free");
endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the Unicode text decoder: directed streams, then random ones.
// Depends on utd_pkg, utd_byte_if, utd_cp_if and the unicode_text_decoder top level.
module testbench;
    import utd_pkg::*;

    // The run is cut off here if results stop coming.
    localparam int LIMIT_CYCLES = 200000;
    // No new random stream is started once this many bytes have been accepted.
    localparam int RANDOM_BYTES = 1500;
    // Wait this long after the last owed result before treating the decoder as idle.
    localparam int SETTLE_CYCLES = 6;

    // One decoded result as the consumer side sees it.
    typedef struct packed {
        logic [CP_W-1:0]     code_point;
        logic [STATUS_W-1:0] status;
        logic                end_mark;
    } t_cp_result;

    // What one byte does to the stream.
    typedef enum logic [1:0] {DEC_NONE, DEC_CODE_POINT, DEC_ERROR} t_decode_kind;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_wr_en;
    logic [ENC_W-1:0] cfg_wr_data;

    utd_byte_if byte_ch ();
    utd_cp_if   cp_ch ();

    unicode_text_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (byte_ch),
        .o_out         (cp_ch)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the decoder. It follows every accepted byte and every mode
    // write, so it always knows what the block should say next.
    logic [ENC_W-1:0] enc_mode;
    logic [CP_W-1:0]  acc;
    logic [2:0]       remaining;
    logic [2:0]       seq_len;
    logic             hi_pending;
    logic             stream_start;
    logic             dropping;

    // Results that the decoder still owes, oldest first.
    t_cp_result pending_code_points[$];

    // Bytes of the stream that is about to be sent.
    logic [7:0] stream_bytes[$];

    int  bytes_sent;
    int  mismatch_count;
    int  cycle_count;
    int  out_wait;
    // When set, the matching side never idles. This gives runs at full rate.
    bit  in_quiet;
    bit  out_quiet;

    task automatic restart_decoder_state();
        acc          = '0;
        remaining    = '0;
        seq_len      = '0;
        hi_pending   = 1'b0;
        stream_start = 1'b1;
        dropping     = 1'b0;
    endtask

    task automatic push_result(input logic [CP_W-1:0] cp, input logic [STATUS_W-1:0] st,
                               input logic end_mark);
        t_cp_result r;
        r.code_point = cp;
        r.status     = st;
        r.end_mark   = end_mark;
        pending_code_points.insert(pending_code_points.size(), r);
    endtask

    // Adds one byte at the end of the stream being built.
    task automatic append_byte(input logic [7:0] b);
        stream_bytes.insert(stream_bytes.size(), b);
    endtask

    // Works out the result, if any, of one accepted byte and updates the shadow state.
    task automatic decode_byte(input logic [7:0] b, input logic last);
        t_decode_kind    kind;
        logic [CP_W-1:0] cp;
        logic [CP_W-1:0] v;
        logic [CP_W-1:0] least;
        logic [7:0]      first;
        logic [15:0]     unit;
        logic [9:0]      hi;
        kind = DEC_NONE;
        cp   = '0;

        // After an error, everything up to the last byte is thrown away.
        if (dropping) begin
            if (last) begin
                push_result('0, ST_END, 1'b1);
                restart_decoder_state();
            end
            return;
        end

        case (enc_mode)
            ENC_UTF8, ENC_UTF8_BOM: begin
                if (remaining == 0) begin
                    if (b <= 8'h7F) begin
                        cp   = {13'd0, b};
                        kind = DEC_CODE_POINT;
                    end else if (b[7:5] == 3'b110) begin
                        acc = {16'd0, b[4:0]}; seq_len = 3'd2; remaining = 3'd1;
                    end else if (b[7:4] == 4'b1110) begin
                        acc = {17'd0, b[3:0]}; seq_len = 3'd3; remaining = 3'd2;
                    end else if (b[7:3] == 5'b11110) begin
                        acc = {18'd0, b[2:0]}; seq_len = 3'd4; remaining = 3'd3;
                    end else begin
                        // A stray continuation byte or a lead byte from 0xF8 up.
                        kind = DEC_ERROR;
                    end
                end else if (b[7:6] != 2'b10) begin
                    kind = DEC_ERROR;
                end else begin
                    acc       = {acc[14:0], b[5:0]};
                    remaining = remaining - 3'd1;
                    if (remaining == 0) begin
                        // The sequence is complete. Overlong forms, surrogates and
                        // values past the top of the code space are only caught here.
                        v       = acc;
                        least   = (seq_len == 3'd2) ? 21'h80 :
                                  (seq_len == 3'd3) ? 21'h800 : SUPP_BASE;
                        acc     = '0;
                        seq_len = '0;
                        if (v < least || v > CP_MAX || (v >= SURR_MIN && v <= SURR_MAX)) begin
                            kind = DEC_ERROR;
                        end else begin
                            cp   = v;
                            kind = DEC_CODE_POINT;
                        end
                    end
                end
            end
            ENC_UTF16LE, ENC_UTF16BE: begin
                if (remaining == 0) begin
                    // Hold the first byte of the unit. Keep the high surrogate offset.
                    acc       = {3'd0, b, acc[9:0]};
                    remaining = 3'd1;
                end else begin
                    first     = acc[17:10];
                    acc       = {11'd0, acc[9:0]};
                    remaining = '0;
                    unit      = (enc_mode == ENC_UTF16LE) ? {b, first} : {first, b};
                    if (hi_pending) begin
                        hi         = acc[9:0];
                        hi_pending = 1'b0;
                        acc        = '0;
                        if (unit < LO_SURR_FIRST || unit > LO_SURR_LAST) begin
                            kind = DEC_ERROR;
                        end else begin
                            cp   = SUPP_BASE + {1'b0, hi, unit[9:0]};
                            kind = DEC_CODE_POINT;
                        end
                    end else if (unit >= HI_SURR_FIRST && unit <= HI_SURR_LAST) begin
                        acc        = {11'd0, unit[9:0]};
                        hi_pending = 1'b1;
                    end else if (unit >= LO_SURR_FIRST && unit <= LO_SURR_LAST) begin
                        kind = DEC_ERROR;
                    end else begin
                        cp   = {5'd0, unit};
                        kind = DEC_CODE_POINT;
                    end
                end
            end
            ENC_ANSI: begin
                if (b > 8'h7F) begin
                    kind = DEC_ERROR;
                end else begin
                    cp   = {13'd0, b};
                    kind = DEC_CODE_POINT;
                end
            end
            default: kind = DEC_ERROR;
        endcase

        // A byte-order mark as the first character of a Unicode stream is swallowed.
        // ANSI has no such mark.
        if (kind == DEC_CODE_POINT) begin
            if (stream_start && cp == BOM_CP && enc_mode <= ENC_UTF16BE) kind = DEC_NONE;
            stream_start = 1'b0;
        end
        // If the stream ends inside a sequence or a surrogate pair, that is an error.
        if (kind == DEC_NONE && last && (remaining != 0 || hi_pending)) kind = DEC_ERROR;

        if (kind == DEC_ERROR) begin
            push_result('0, ST_ERROR, last);
            if (last) restart_decoder_state();
            else dropping = 1'b1;
        end else if (kind == DEC_CODE_POINT) begin
            push_result(cp, ST_CODE_POINT, last);
            if (last) restart_decoder_state();
        end else if (last) begin
            push_result('0, ST_END, 1'b1);
            restart_decoder_state();
        end
    endtask

    // Sends one byte after a random gap and waits for the decoder to take it.
    // Valid stays high straight into the next byte when that byte has no gap.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= last;
        do @(posedge i_clk); while (!byte_ch.ready);
        decode_byte(b, last);
        bytes_sent++;
    endtask

    // Sends the queued stream bytes. The final byte carries the last mark only
    // if the stream is to be closed.
    task automatic send_stream(input bit close_stream);
        int i;
        for (i = 0; i < stream_bytes.size(); i++) begin
            send_byte(stream_bytes[i], close_stream && (i == stream_bytes.size() - 1));
        end
        stream_bytes.delete();
    endtask

    // Stops sending and waits until every owed result has arrived and the pipeline is empty.
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        while (pending_code_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mode writes are only made while the decoder is idle. They also restart the stream.
    task automatic set_mode(input logic [ENC_W-1:0] mode);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        enc_mode = mode;
        restart_decoder_state();
    endtask

    function automatic logic [CP_W-1:0] pick_code_point();
        case ($urandom_range(0, 9))
            0, 1, 2: pick_code_point = CP_W'($urandom_range(0, 'h7F));
            3:       pick_code_point = CP_W'($urandom_range('h80, 'h7FF));
            4:       pick_code_point = CP_W'($urandom_range('h800, 'hFFFF));
            5:       pick_code_point = CP_W'($urandom_range('h10000, 'h10FFFF));
            6: begin
                // Edges of the UTF-8 length classes and of the code space.
                case ($urandom_range(0, 7))
                    0:       pick_code_point = 21'h0;
                    1:       pick_code_point = 21'h7F;
                    2:       pick_code_point = 21'h80;
                    3:       pick_code_point = 21'h7FF;
                    4:       pick_code_point = 21'h800;
                    5:       pick_code_point = 21'hFFFF;
                    6:       pick_code_point = SUPP_BASE;
                    default: pick_code_point = CP_MAX;
                endcase
            end
            7, 8:    pick_code_point = BOM_CP;
            default: pick_code_point = CP_W'($urandom_range('hD800, 'hDFFF));
        endcase
    endfunction

    // Encodes as UTF-8. Now and then the form is overlong, or the value is past
    // the top of the code space.
    task automatic add_utf8(input logic [CP_W-1:0] cp);
        int len;
        len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < SUPP_BASE) ? 3 : 4;
        if (len < 4 && $urandom_range(0, 11) == 0) len++;
        if (len == 4 && $urandom_range(0, 15) == 0) cp = CP_W'($urandom_range('h110000, 'h1FFFFF));
        case (len)
            1: append_byte(cp[7:0]);
            2: begin
                append_byte({3'b110, cp[10:6]});
                append_byte({2'b10, cp[5:0]});
            end
            3: begin
                append_byte({4'b1110, cp[15:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
            default: begin
                append_byte({5'b11110, cp[20:18]});
                append_byte({2'b10, cp[17:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic add_utf16_unit(input logic [15:0] unit);
        if (enc_mode == ENC_UTF16LE) begin
            append_byte(unit[7:0]);
            append_byte(unit[15:8]);
        end else begin
            append_byte(unit[15:8]);
            append_byte(unit[7:0]);
        end
    endtask

    // Encodes as UTF-16. Now and then half of a surrogate pair is left out.
    task automatic add_utf16(input logic [CP_W-1:0] cp);
        logic [CP_W-1:0] off;
        int              drop;
        if (cp < SUPP_BASE) begin
            add_utf16_unit(cp[15:0]);
        end else begin
            off  = cp - SUPP_BASE;
            drop = $urandom_range(0, 31);
            if (drop != 0) add_utf16_unit(HI_SURR_FIRST | {6'd0, off[19:10]});
            if (drop != 1) add_utf16_unit(LO_SURR_FIRST | {6'd0, off[9:0]});
        end
    endtask

    // Builds one random stream in the current mode. Most streams are well formed,
    // some are damaged, and a few are random bytes.
    task automatic build_random_stream();
        int              n_chars;
        int              i;
        int              damage;
        logic [CP_W-1:0] cp;
        stream_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            n_chars = $urandom_range(1, 6);
            for (i = 0; i < n_chars; i++) append_byte(8'($urandom));
            return;
        end
        n_chars = $urandom_range(1, 6);
        for (i = 0; i < n_chars; i++) begin
            cp = pick_code_point();
            case (enc_mode)
                ENC_UTF8, ENC_UTF8_BOM:   add_utf8(cp);
                ENC_UTF16LE, ENC_UTF16BE: add_utf16(cp);
                ENC_ANSI: append_byte(($urandom_range(0, 7) == 0) ?
                                      8'($urandom) : {1'b0, cp[6:0]});
                default:  append_byte(8'($urandom));
            endcase
        end
        damage = $urandom_range(0, 19);
        if (damage == 0) begin
            stream_bytes[$urandom_range(0, stream_bytes.size() - 1)] = 8'($urandom);
        end else if (damage == 1 && stream_bytes.size() > 1) begin
            void'(stream_bytes.pop_back());
        end else if (damage == 2) begin
            // In UTF-16 this leaves an odd length.
            append_byte(8'($urandom));
        end
    endtask

    // Lead bytes of every length, the byte-order mark, the top of the code space,
    // and each kind of UTF-8 fault at the byte where it is caught.
    task automatic test_utf8_forms();
        // Mode 0 is the reset value, so the first streams run before any write.
        stream_bytes = '{8'h00};
        send_stream(1);
        // A mark that is the whole stream gives only the end status.
        stream_bytes = '{8'hEF, 8'hBB, 8'hBF};
        send_stream(1);
        stream_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_stream(1);
        // A lead byte from 0xF8 up is bad as it stands.
        stream_bytes = '{8'hFF};
        send_stream(1);
        // An encoded surrogate fails on its final byte. The rest is dropped until the end.
        stream_bytes = '{8'hED, 8'hA0, 8'h80, 8'h41};
        send_stream(1);
        set_mode(ENC_UTF8_BOM);
        // A missing continuation byte fails on the byte that should have been one.
        stream_bytes = '{8'hC2, 8'h41};
        send_stream(1);
        // The stream ends in the middle of a sequence.
        stream_bytes = '{8'hE2, 8'h82};
        send_stream(1);
        // An overlong form of 0x7F.
        stream_bytes = '{8'hC1, 8'hBF, 8'h7F};
        send_stream(1);
    endtask

    // Surrogate pairs in both byte orders, an unpaired low half, and an odd length.
    task automatic test_utf16_pairs();
        set_mode(ENC_UTF16LE);
        stream_bytes = '{8'hFF, 8'hFE, 8'h3D, 8'hD8, 8'h00, 8'hDE};
        send_stream(1);
        stream_bytes = '{8'h00, 8'hDC, 8'h41, 8'h00};
        send_stream(1);
        set_mode(ENC_UTF16BE);
        stream_bytes = '{8'hD8, 8'h3D, 8'hDE, 8'h00};
        send_stream(1);
        stream_bytes = '{8'h00};
        send_stream(1);
    endtask

    // ANSI takes seven-bit bytes only. A mode without a decoder fails on the first byte.
    task automatic test_ansi_and_unknown_modes();
        set_mode(ENC_ANSI);
        stream_bytes = '{8'h7F, 8'h80};
        send_stream(1);
        set_mode(3'd5);
        stream_bytes = '{8'h41, 8'h42};
        send_stream(1);
        set_mode(3'd7);
        stream_bytes = '{8'h00};
        send_stream(1);
    endtask

    // A mode write in the middle of a stream throws away the partial sequence.
    task automatic test_mode_write_restart();
        set_mode(ENC_UTF8);
        stream_bytes = '{8'hE2, 8'h82};
        send_stream(0);
        set_mode(ENC_UTF16BE);
        stream_bytes = '{8'h00, 8'h41};
        send_stream(1);
    endtask

    // Random streams in random modes. Some stretches run at full rate on one
    // side or on both.
    task automatic test_random_streams();
        logic [ENC_W-1:0] mode;
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 11) == 0) begin
                mode = ($urandom_range(0, 15) == 0) ? ENC_W'($urandom_range(5, 7)) :
                                                      ENC_W'($urandom_range(0, 4));
                set_mode(mode);
            end
            in_quiet  = ($urandom_range(0, 7) == 0);
            out_quiet = ($urandom_range(0, 7) == 0);
            build_random_stream();
            send_stream(1);
        end
        in_quiet  = 1'b0;
        out_quiet = 1'b0;
    endtask

    // Consumer side. Every accepted result is checked against the oldest owed
    // one, then ready may drop for a random wait.
    always @(posedge i_clk) begin
        t_cp_result got;
        t_cp_result want;
        if (i_rst_n && cp_ch.valid && cp_ch.ready) begin
            got = {cp_ch.code_point, cp_ch.status, cp_ch.end_mark};
            if (pending_code_points.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: code point %h status %0d end %0b",
                             got.code_point, got.status, got.end_mark);
            end else begin
                want = pending_code_points.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected cp %h st %0d end %0b, got cp %h st %0d end %0b",
                                 want.code_point, want.status, want.end_mark,
                                 got.code_point, got.status, got.end_mark);
                end
            end
            out_wait = out_quiet ? 0 : $urandom_range(0, 5);
        end
        if (out_wait == 0) begin
            cp_ch.ready <= 1'b1;
        end else begin
            cp_ch.ready <= 1'b0;
            out_wait--;
        end
    end

    // A stuck handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = ENC_UTF8;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        cp_ch.ready       = 1'b0;
        mismatch_count    = 0;
        cycle_count       = 0;
        out_wait          = 0;
        in_quiet          = 1'b0;
        out_quiet         = 1'b0;
        enc_mode          = ENC_UTF8;
        restart_decoder_state();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_utf8_forms();
        test_utf16_pairs();
        test_ansi_and_unknown_modes();
        test_mode_write_restart();
        test_random_streams();

        wait_drained();
        if (mismatch_count == 0 && pending_code_points.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/utd_pkg.sv
design/utd_byte_if.sv
design/utd_cp_if.sv
design/utd_front.sv
design/utd_queue.sv
design/utd_back.sv
design/unicode_text_decoder.sv
test/testbench.sv
